@@ rtl/apf_pkg.sv @@
`default_nettype none

package apf_pkg;

   // defaults for the top level parameters
   localparam int DEFAULT_QUEUE_DEPTH = 16;
   localparam int DEFAULT_MSG_WIDTH   = 32;

   // fixed widths of the channel fields
   localparam int MSG_IN_W    = 32;
   localparam int MSG_OUT_W   = 32;
   localparam int STATUS_W    = 3;
   localparam int COUNT_OUT_W = 5;

   // request codes
   localparam logic OP_SEND     = 1'b0;
   localparam logic OP_RECV     = 1'b1;
   localparam logic KIND_NORMAL = 1'b0;
   localparam logic KIND_ALARM  = 1'b1;

   // response status codes
   localparam logic [STATUS_W-1:0] STS_SENT    = 3'd0;
   localparam logic [STATUS_W-1:0] STS_NO_ROOM = 3'd1;
   localparam logic [STATUS_W-1:0] STS_NO_MSG  = 3'd2;
   localparam logic [STATUS_W-1:0] STS_ALARM   = 3'd3;
   localparam logic [STATUS_W-1:0] STS_NORMAL  = 3'd4;

   // datapath status seen by the controller
   typedef struct packed {
      logic alarm_valid;
      logic fifo_full;
      logic fifo_empty;
   } dp_stat_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic                load;
      logic                push;
      logic                pop;
      logic                alarm_set;
      logic                alarm_take;
      logic [STATUS_W-1:0] status;
   } dp_cmd_type;

endpackage

`default_nettype wire

@@ rtl/apf_req_if.sv @@
`default_nettype none

interface apf_req_if;
   logic                         valid;
   logic                         ready;
   logic                         op;
   logic                         kind;
   logic [apf_pkg::MSG_IN_W-1:0] msg_in;

   modport source (output valid, output op, output kind, output msg_in, input ready);
   modport sink (input valid, input op, input kind, input msg_in, output ready);
endinterface

`default_nettype wire

@@ rtl/apf_rsp_if.sv @@
`default_nettype none

interface apf_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [apf_pkg::STATUS_W-1:0]    status;
   logic [apf_pkg::MSG_OUT_W-1:0]   msg_out;
   logic [apf_pkg::COUNT_OUT_W-1:0] total_count;
   logic                            alarm_pending;

   modport source (output valid, output status, output msg_out, output total_count,
                   output alarm_pending, input ready);
   modport sink (input valid, input status, input msg_out, input total_count,
                 input alarm_pending, output ready);
endinterface

`default_nettype wire

@@ rtl/alarm_priority_fifo_core.sv @@
// Message queue with one priority alarm slot. A send request stores a normal
// message at the tail of a QUEUE_DEPTH-entry FIFO or an alarm message in the
// single alarm slot, and is answered no_room when the target is occupied. A
// receive request returns the pending alarm first, else the oldest normal
// message, else no_msg. Each request yields exactly one response carrying the
// status, the received word (zero when none), the number of held messages and
// the alarm flag as they stand after the request. One request is handled at a
// time: once it is taken, its response is shown from the next cycle on, and
// the next request is taken in the cycle after the response is taken. Between
// a request and its response lie the response registers and the registered
// read of the FIFO memory. The FIFO memory has no reset; pointers, count and
// the alarm slot are cleared by reset.
`default_nettype none

module alarm_priority_fifo_core #(
   parameter int QUEUE_DEPTH = apf_pkg::DEFAULT_QUEUE_DEPTH,
   parameter int MSG_WIDTH   = apf_pkg::DEFAULT_MSG_WIDTH
) (
   input wire logic   clock,
   input wire logic   reset,
   apf_req_if.sink    req_chan,
   apf_rsp_if.source  rsp_chan
);

   apf_pkg::dp_cmd_type  cmd;
   apf_pkg::dp_stat_type stat;

   apf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.op),
      .req_kind  (req_chan.kind),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid)
   );

   apf_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .MSG_WIDTH   (MSG_WIDTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .msg_in        (req_chan.msg_in),
      .stat          (stat),
      .status        (rsp_chan.status),
      .msg_out       (rsp_chan.msg_out),
      .total_count   (rsp_chan.total_count),
      .alarm_pending (rsp_chan.alarm_pending)
   );

endmodule

`default_nettype wire

@@ rtl/apf_ctrl.sv @@
`default_nettype none

module apf_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_op,
   input  wire logic                 req_kind,
   input  wire logic                 rsp_ready,
   input  wire apf_pkg::dp_stat_type stat,
   output apf_pkg::dp_cmd_type       cmd,
   output logic                      req_ready,
   output logic                      rsp_valid
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RESP = 1'b1;

   logic state_ff;
   logic state_in;
   logic accept;
   logic push_d;
   logic pop_d;
   logic set_d;
   logic take_d;
   logic [apf_pkg::STATUS_W-1:0] status_d;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign accept    = req_valid && req_ready;

   // decide what the request does against the current queue state
   always_comb begin
      push_d   = 1'b0;
      pop_d    = 1'b0;
      set_d    = 1'b0;
      take_d   = 1'b0;
      status_d = apf_pkg::STS_SENT;
      if (req_op == apf_pkg::OP_SEND) begin
         priority if (req_kind == apf_pkg::KIND_ALARM && stat.alarm_valid) begin
            status_d = apf_pkg::STS_NO_ROOM;
         end else if (req_kind == apf_pkg::KIND_ALARM) begin
            set_d    = 1'b1;
            status_d = apf_pkg::STS_SENT;
         end else if (stat.fifo_full) begin
            status_d = apf_pkg::STS_NO_ROOM;
         end else begin
            push_d   = 1'b1;
            status_d = apf_pkg::STS_SENT;
         end
      end else begin
         priority if (stat.alarm_valid) begin
            take_d   = 1'b1;
            status_d = apf_pkg::STS_ALARM;
         end else if (!stat.fifo_empty) begin
            pop_d    = 1'b1;
            status_d = apf_pkg::STS_NORMAL;
         end else begin
            status_d = apf_pkg::STS_NO_MSG;
         end
      end
   end

   always_comb begin
      cmd.load       = accept;
      cmd.push       = accept && push_d;
      cmd.pop        = accept && pop_d;
      cmd.alarm_set  = accept && set_d;
      cmd.alarm_take = accept && take_d;
      cmd.status     = status_d;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/apf_dp.sv @@
`default_nettype none

module apf_dp #(
   parameter int QUEUE_DEPTH = apf_pkg::DEFAULT_QUEUE_DEPTH,
   parameter int MSG_WIDTH   = apf_pkg::DEFAULT_MSG_WIDTH
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire apf_pkg::dp_cmd_type             cmd,
   input  wire logic [apf_pkg::MSG_IN_W-1:0]    msg_in,
   output apf_pkg::dp_stat_type                 stat,
   output logic [apf_pkg::STATUS_W-1:0]         status,
   output logic [apf_pkg::MSG_OUT_W-1:0]        msg_out,
   output logic [apf_pkg::COUNT_OUT_W-1:0]      total_count,
   output logic                                 alarm_pending
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   logic [MSG_WIDTH-1:0] mem [QUEUE_DEPTH];

   logic [PTR_W-1:0]              rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]              wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic                          alarm_valid_ff, alarm_valid_in;
   logic [MSG_WIDTH-1:0]          alarm_word_ff, alarm_word_in;
   logic [MSG_WIDTH-1:0]          rdata_ff;
   logic [MSG_WIDTH-1:0]          msg_ff, msg_in_d;
   logic                          from_mem_ff;
   logic [apf_pkg::STATUS_W-1:0]  status_ff;
   logic [MSG_WIDTH-1:0]          wdata;
   logic [CNT_W:0]                total_sum;

   assign wdata = MSG_WIDTH'(msg_in);

   assign stat.alarm_valid = alarm_valid_ff;
   assign stat.fifo_full   = (count_ff == CNT_FULL);
   assign stat.fifo_empty  = (count_ff == '0);

   always_comb begin
      rd_ptr_in      = rd_ptr_ff;
      wr_ptr_in      = wr_ptr_ff;
      count_in       = count_ff;
      alarm_valid_in = alarm_valid_ff;
      alarm_word_in  = alarm_word_ff;
      priority if (cmd.push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         count_in  = count_ff + 1'b1;
      end else if (cmd.pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         count_in  = count_ff - 1'b1;
      end else if (cmd.alarm_set) begin
         alarm_valid_in = 1'b1;
         alarm_word_in  = wdata;
      end else if (cmd.alarm_take) begin
         alarm_valid_in = 1'b0;
      end else begin
         count_in = count_ff;
      end
   end

   // word returned without a memory read: the alarm, or zero
   assign msg_in_d = cmd.alarm_take ? alarm_word_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff      <= '0;
         wr_ptr_ff      <= '0;
         count_ff       <= '0;
         alarm_valid_ff <= 1'b0;
         alarm_word_ff  <= '0;
      end else begin
         rd_ptr_ff      <= rd_ptr_in;
         wr_ptr_ff      <= wr_ptr_in;
         count_ff       <= count_in;
         alarm_valid_ff <= alarm_valid_in;
         alarm_word_ff  <= alarm_word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pop) begin
         rdata_ff <= mem[rd_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         status_ff   <= cmd.status;
         msg_ff      <= msg_in_d;
         from_mem_ff <= cmd.pop;
      end
   end

   // count and alarm flag hold their post-request values while the response waits
   assign total_sum     = {1'b0, count_ff} + {{CNT_W{1'b0}}, alarm_valid_ff};
   assign total_count   = apf_pkg::COUNT_OUT_W'(total_sum);
   assign alarm_pending = alarm_valid_ff;
   assign status        = status_ff;
   assign msg_out       = from_mem_ff ? apf_pkg::MSG_OUT_W'(rdata_ff)
                                      : apf_pkg::MSG_OUT_W'(msg_ff);

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

   localparam int QDEPTH = apf_pkg::DEFAULT_QUEUE_DEPTH;

   typedef struct {
      logic                         op;
      logic                         kind;
      logic [apf_pkg::MSG_IN_W-1:0] word;
   } mail_request_type;

   typedef struct {
      logic [apf_pkg::STATUS_W-1:0]    status;
      logic [apf_pkg::MSG_OUT_W-1:0]   word;
      logic [apf_pkg::COUNT_OUT_W-1:0] total;
      logic                            alarm;
   } mail_reply_type;

   logic clock;
   logic reset;

   apf_req_if req_chan ();
   apf_rsp_if rsp_chan ();

   alarm_priority_fifo_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   mail_request_type pending_requests[$];
   mail_reply_type   expected_replies[$];

   // shadow copy of the mailbox contents
   logic [apf_pkg::MSG_IN_W-1:0] shadow_store [QDEPTH];
   int                           shadow_rd;
   int                           shadow_wr;
   int                           shadow_normals;
   logic [apf_pkg::MSG_IN_W-1:0] shadow_alarm_word;
   logic                         shadow_alarm_held;

   int  mismatches;
   int  replies_taken;
   bit  req_fire;
   bit  rsp_fire;
   int  req_gap_left;
   int  req_calm;
   int  rsp_stall_left;
   int  rsp_calm;

   always #2 clock = ~clock;

   function automatic mail_reply_type predict_reply(mail_request_type rq);
      mail_reply_type rp;
      rp.word = '0;
      if (rq.op == apf_pkg::OP_SEND) begin
         if (rq.kind == apf_pkg::KIND_ALARM) begin
            if (shadow_alarm_held) begin
               rp.status = apf_pkg::STS_NO_ROOM;
            end else begin
               shadow_alarm_word = rq.word;
               shadow_alarm_held = 1'b1;
               rp.status = apf_pkg::STS_SENT;
            end
         end else if (shadow_normals >= QDEPTH) begin
            rp.status = apf_pkg::STS_NO_ROOM;
         end else begin
            shadow_store[shadow_wr] = rq.word;
            shadow_wr = (shadow_wr + 1) % QDEPTH;
            shadow_normals++;
            rp.status = apf_pkg::STS_SENT;
         end
      end else begin
         if (shadow_alarm_held) begin
            rp.word = shadow_alarm_word;
            shadow_alarm_held = 1'b0;
            rp.status = apf_pkg::STS_ALARM;
         end else if (shadow_normals > 0) begin
            rp.word = shadow_store[shadow_rd];
            shadow_rd = (shadow_rd + 1) % QDEPTH;
            shadow_normals--;
            rp.status = apf_pkg::STS_NORMAL;
         end else begin
            rp.status = apf_pkg::STS_NO_MSG;
         end
      end
      rp.total = apf_pkg::COUNT_OUT_W'(shadow_normals + int'(shadow_alarm_held));
      rp.alarm = shadow_alarm_held;
      return rp;
   endfunction

   // mostly short gaps, a few long ones, and now and then a run with none
   function automatic int pick_gap(inout int calm_left);
      int roll;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
         calm_left = $urandom_range(15, 40);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic add_request(logic op, logic kind, logic [apf_pkg::MSG_IN_W-1:0] word);
      mail_request_type rq;
      rq.op   = op;
      rq.kind = kind;
      rq.word = word;
      pending_requests.push_back(rq);
   endtask

   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // request driver
   always @(negedge clock) begin
      mail_request_type rq;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_fire) begin
         if (req_gap_left > 0) begin
            req_chan.valid <= 1'b0;
            req_gap_left--;
         end else if (pending_requests.size() != 0) begin
            rq = pending_requests.pop_front();
            req_chan.op     <= rq.op;
            req_chan.kind   <= rq.kind;
            req_chan.msg_in <= rq.word;
            req_chan.valid  <= 1'b1;
            req_gap_left = pick_gap(req_calm);
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // reply receiver, with two long hold-offs so the core backs up
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_fire) begin
            rsp_stall_left = pick_gap(rsp_calm);
            if (replies_taken == 20 || replies_taken == 500)
               rsp_stall_left = 120;
         end
         if (rsp_stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            rsp_stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // monitor: predict on each accepted request, check each accepted reply
   always @(posedge clock) begin
      mail_request_type rq;
      mail_reply_type   want;
      if (reset) begin
         req_fire <= 1'b0;
         rsp_fire <= 1'b0;
      end else begin
         req_fire <= req_chan.valid && req_chan.ready;
         rsp_fire <= rsp_chan.valid && rsp_chan.ready;
         if (req_chan.valid && req_chan.ready) begin
            rq.op   = req_chan.op;
            rq.kind = req_chan.kind;
            rq.word = req_chan.msg_in;
            expected_replies.push_back(predict_reply(rq));
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            replies_taken++;
            if (expected_replies.size() == 0) begin
               $display("%0t: reply with none expected, expected nothing, actual status %0d",
                        $time, rsp_chan.status);
               mismatches++;
            end else begin
               want = expected_replies.pop_front();
               compare_field("status", 32'(want.status), 32'(rsp_chan.status));
               compare_field("msg_out", want.word, rsp_chan.msg_out);
               compare_field("total_count", 32'(want.total), 32'(rsp_chan.total_count));
               compare_field("alarm_pending", 32'(want.alarm), 32'(rsp_chan.alarm_pending));
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      int random_total;
      int phase_len;
      int send_pct;
      int roll;
      logic [apf_pkg::MSG_IN_W-1:0] word;

      clock = 1'b0;
      reset = 1'b1;
      req_chan.valid  = 1'b0;
      req_chan.op     = apf_pkg::OP_SEND;
      req_chan.kind   = apf_pkg::KIND_NORMAL;
      req_chan.msg_in = '0;
      rsp_chan.ready  = 1'b0;
      shadow_rd = 0;
      shadow_wr = 0;
      shadow_normals = 0;
      shadow_alarm_word = '0;
      shadow_alarm_held = 1'b0;
      mismatches = 0;
      replies_taken = 0;
      req_gap_left = 0;
      req_calm = 0;
      rsp_stall_left = 0;
      rsp_calm = 0;

      // directed: empty receive, alarm slot busy, full fifo, priority order
      add_request(apf_pkg::OP_RECV, apf_pkg::KIND_ALARM, $urandom);
      add_request(apf_pkg::OP_SEND, apf_pkg::KIND_ALARM, '1);
      add_request(apf_pkg::OP_SEND, apf_pkg::KIND_ALARM, '0);
      for (int i = 0; i < QDEPTH; i++)
         add_request(apf_pkg::OP_SEND, apf_pkg::KIND_NORMAL,
                     (i == 0) ? '0 : (i == QDEPTH - 1) ? '1 : $urandom);
      add_request(apf_pkg::OP_SEND, apf_pkg::KIND_NORMAL, 32'h5a5a_5a5a);
      add_request(apf_pkg::OP_RECV, apf_pkg::KIND_ALARM, '1);
      add_request(apf_pkg::OP_RECV, apf_pkg::KIND_NORMAL, '0);
      add_request(apf_pkg::OP_SEND, apf_pkg::KIND_ALARM, '0);

      // random phases that lean toward filling, draining or neither
      random_total = 0;
      while (random_total < 800) begin
         phase_len = $urandom_range(30, 80);
         case ($urandom_range(0, 2))
            0: send_pct = 80;
            1: send_pct = 20;
            default: send_pct = 50;
         endcase
         repeat (phase_len) begin
            roll = $urandom_range(0, 9);
            word = (roll == 0) ? '0 : (roll == 1) ? '1 : $urandom;
            add_request(($urandom_range(0, 99) < send_pct) ? apf_pkg::OP_SEND
                                                          : apf_pkg::OP_RECV,
                        ($urandom_range(0, 99) < 25) ? apf_pkg::KIND_ALARM
                                                     : apf_pkg::KIND_NORMAL,
                        word);
         end
         random_total += phase_len;
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_chan.valid) @(negedge clock);
      while (expected_replies.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);

      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
